FILE: rtl/sfm_pkg.sv
`default_nettype none

package sfm_pkg;

    localparam int PATTERN_BYTES = 16;
    localparam int LEN_BITS      = 5;
    localparam int LIMIT_BITS    = 16;
    localparam int OUT_IDX_BITS  = 16;
    localparam int CFG_BITS      = 64;
    localparam int CFG_IDX_BITS  = 3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_PAT_LOW  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PAT_HIGH = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PAT_LEN  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LIMIT    = 3'd3;

    typedef logic [7:0] byte_t;
    typedef byte_t [PATTERN_BYTES-1:0] pattern_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/sfm_cell.sv
`default_nettype none

module sfm_cell #(
    parameter int CELL_INDEX = 0
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire sfm_pkg::cell_ctrl_t         ctrl,
    input  wire sfm_pkg::byte_t              byte_in,
    input  wire sfm_pkg::pattern_t           pattern,
    input  wire [sfm_pkg::LEN_BITS-1:0]      len,
    output sfm_pkg::byte_t                   byte_out,
    output logic                             hit
);
    import sfm_pkg::*;

    byte_t               byte_reg;
    byte_t               byte_next;
    logic                active;
    logic [LEN_BITS-1:0] sel;
    byte_t               expected;

    // cell k holds window byte k and checks it against pattern byte len-1-k
    always_comb
    begin
        active   = int'(len) > CELL_INDEX;
        sel      = len - LEN_BITS'(1) - LEN_BITS'(CELL_INDEX);
        expected = sel[LEN_BITS-1] ? 8'd0 : pattern[sel[LEN_BITS-2:0]];
        hit      = !active || (byte_in == expected);
    end

    always_comb
    begin
        byte_next = byte_reg;
        if (ctrl.clear)
        begin
            byte_next = 8'd0;
        end
        else if (ctrl.shift)
        begin
            byte_next = byte_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= 8'd0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign byte_out = byte_reg;

endmodule

`default_nettype wire

FILE: rtl/substring_first_match.sv
`default_nettype none
// Streaming first-match substring search over a row of window cells.
// A result beat is registered in the output register, or the skid entry while
// the output stalls. Throughput: one text beat per cycle while the skid entry
// is empty; output register plus skid keep input flowing while a result waits.
// Reset: asynchronous active low; clears window, position, done flag, pattern
// registers to zero and search_limit to 65535.

module substring_first_match #(
    parameter int MAX_PATTERN = 16,
    parameter int INDEX_BITS  = 16
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_write,
    input  wire [sfm_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  wire [sfm_pkg::CFG_BITS-1:0]          cfg_data,
    input  wire                                  text_valid,
    output logic                                 text_stall,
    input  wire [7:0]                            text_byte,
    output logic                                 result_valid,
    input  wire                                  result_stall,
    output logic                                 found,
    output logic [sfm_pkg::OUT_IDX_BITS-1:0]     match_index
);
    import sfm_pkg::*;

    localparam int CW = (INDEX_BITS + 1 > LIMIT_BITS + 1) ? INDEX_BITS + 1 : LIMIT_BITS + 1;

    logic [CFG_BITS-1:0]   pat_low_reg;
    logic [CFG_BITS-1:0]   pat_high_reg;
    logic [LEN_BITS-1:0]   pat_len_reg;
    logic [LIMIT_BITS-1:0] limit_reg;

    logic [INDEX_BITS-1:0] pos_reg;
    logic [INDEX_BITS-1:0] pos_next;
    logic                  done_reg;
    logic                  done_next;

    logic                    out_valid_reg;
    logic                    out_found_reg;
    logic [OUT_IDX_BITS-1:0] out_index_reg;
    logic                    skid_valid_reg;
    logic                    skid_found_reg;
    logic [OUT_IDX_BITS-1:0] skid_index_reg;

    pattern_t              pattern;
    logic [LEN_BITS-1:0]   len;
    cell_ctrl_t            ctrl;
    byte_t                 chain [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] hits;

    logic                    accept;
    logic                    is_term;
    logic                    examine;
    logic                    match;
    logic                    emit;
    logic                    res_found;
    logic [OUT_IDX_BITS-1:0] res_index;
    logic [CW-1:0]           pp1;
    logic [CW-1:0]           len_w;
    logic [CW-1:0]           lim_w;
    logic                    out_take;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= '0;
            limit_reg    <= '1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_PAT_LOW:  pat_low_reg  <= cfg_data;
                CFG_PAT_HIGH: pat_high_reg <= cfg_data;
                CFG_PAT_LEN:  pat_len_reg  <= cfg_data[LEN_BITS-1:0];
                CFG_LIMIT:    limit_reg    <= cfg_data[LIMIT_BITS-1:0];
                default:      ;
            endcase
        end
    end

    assign pattern = pattern_t'({pat_high_reg, pat_low_reg});

    always_comb
    begin
        if (int'(pat_len_reg) > MAX_PATTERN)
        begin
            len = LEN_BITS'(MAX_PATTERN);
        end
        else
        begin
            len = pat_len_reg;
        end
    end

    // window cells
    assign accept     = text_valid && !text_stall;
    assign is_term    = (text_byte == 8'd0);
    assign ctrl.shift = accept && !is_term;
    assign ctrl.clear = accept && is_term;

    genvar k;
    generate
        for (k = 0; k < MAX_PATTERN; k++)
        begin : g_cell
            sfm_cell #(
                .CELL_INDEX(k)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .byte_in  ((k == 0) ? byte_t'(text_byte) : chain[(k == 0) ? 0 : k - 1]),
                .pattern  (pattern),
                .len      (len),
                .byte_out (chain[k]),
                .hit      (hits[k])
            );
        end
    endgenerate

    // match decision
    always_comb
    begin
        pp1     = CW'(pos_reg) + CW'(1);
        len_w   = CW'(len);
        lim_w   = CW'(limit_reg);
        examine = !done_reg && (pos_reg != '1);
        if (len == '0)
        begin
            match     = (pos_reg == '0) && (limit_reg != '0);
            res_index = '0;
        end
        else
        begin
            match     = (pp1 >= len_w) && (pp1 <= lim_w) && (&hits);
            res_index = OUT_IDX_BITS'(pp1 - len_w);
        end
        if (is_term)
        begin
            emit      = accept && !done_reg;
            res_found = 1'b0;
            res_index = '0;
        end
        else
        begin
            emit      = accept && examine && match;
            res_found = 1'b1;
        end
    end

    always_comb
    begin
        pos_next  = pos_reg;
        done_next = done_reg;
        if (accept)
        begin
            if (is_term)
            begin
                pos_next  = '0;
                done_next = 1'b0;
            end
            else
            begin
                if (pos_reg != '1)
                begin
                    pos_next = pos_reg + INDEX_BITS'(1);
                end
                if (emit)
                begin
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            done_reg <= done_next;
        end
    end

    // output register with one skid entry
    assign out_take   = out_valid_reg && !result_stall;
    assign text_stall = skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_take || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= emit;
            end
        end
        else if (emit)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_found_reg <= skid_found_reg;
                out_index_reg <= skid_index_reg;
            end
            else if (emit)
            begin
                out_found_reg <= res_found;
                out_index_reg <= res_index;
            end
        end
        else if (emit)
        begin
            skid_found_reg <= res_found;
            skid_index_reg <= res_index;
        end
    end

    assign result_valid = out_valid_reg;
    assign found        = out_found_reg;
    assign match_index  = out_index_reg;

endmodule

`default_nettype wire

FILE: tb/tb.sv
`default_nettype none

module tb;

    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int RANDOM_ITEMS = 1800;
    localparam int HOLD_CYCLES  = 300;

    typedef struct packed {
        logic        found;
        logic [15:0] index;
    } match_t;

    class match_scoreboard;
        sfm_pkg::pattern_t pattern;
        logic [4:0]        pat_len;
        logic [15:0]       limit;
        sfm_pkg::byte_t    window [16];
        logic [15:0]       pos;
        bit                done;
        match_t            match_q [$];
        int                errors;

        function new();
            pattern = '0;
            pat_len = '0;
            limit   = 16'hFFFF;
            errors  = 0;
            clear_string();
        endfunction

        function void clear_string();
            foreach (window[i])
                window[i] = '0;
            pos  = '0;
            done = 0;
        endfunction

        function void write_reg(logic [sfm_pkg::CFG_IDX_BITS-1:0] idx, logic [63:0] v);
            case (idx)
                sfm_pkg::CFG_PAT_LOW:  pattern[7:0]  = v;
                sfm_pkg::CFG_PAT_HIGH: pattern[15:8] = v;
                sfm_pkg::CFG_PAT_LEN:  pat_len       = v[4:0];
                sfm_pkg::CFG_LIMIT:    limit         = v[15:0];
                default: ;
            endcase
        endfunction

        function void note_text(sfm_pkg::byte_t b);
            int p;
            int len;
            int k;
            bit was_done;
            if (b == 8'd0)
            begin
                was_done = done;
                clear_string();
                if (!was_done)
                    match_q.push_back({1'b0, 16'd0});
                return;
            end
            for (k = 15; k > 0; k--)
                window[k] = window[k-1];
            window[0] = b;
            p = pos;
            if (pos != 16'hFFFF)
                pos++;
            if (done || p == 'hFFFF)
                return;
            len = (pat_len > 16) ? 16 : pat_len;
            if (len == 0)
            begin
                if (p == 0 && limit != 0)
                begin
                    done = 1;
                    match_q.push_back({1'b1, 16'd0});
                end
                return;
            end
            if (p + 1 < len || p + 1 > limit)
                return;
            for (k = 0; k < len; k++)
                if (window[len-1-k] != pattern[k])
                    return;
            done = 1;
            match_q.push_back({1'b1, 16'(p + 1 - len)});
        endfunction

        function void check_result(logic f, logic [15:0] mi);
            match_t e;
            if (match_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual found=%0d index=%0d",
                         $time, f, mi);
                return;
            end
            e = match_q.pop_front();
            if (f !== e.found)
            begin
                errors++;
                $display("%0t: found mismatch, expected %0d actual %0d", $time, e.found, f);
            end
            if (mi !== e.index)
            begin
                errors++;
                $display("%0t: match_index mismatch, expected %0d actual %0d",
                         $time, e.index, mi);
            end
        endfunction

        function int outstanding();
            return match_q.size();
        endfunction
    endclass

    logic                              clk;
    logic                              rst_n;
    logic                              cfg_write;
    logic [sfm_pkg::CFG_IDX_BITS-1:0]  cfg_index;
    logic [sfm_pkg::CFG_BITS-1:0]      cfg_data;
    logic                              text_valid;
    logic                              text_stall;
    logic [7:0]                        text_byte;
    logic                              result_valid;
    logic                              result_stall;
    logic                              found;
    logic [sfm_pkg::OUT_IDX_BITS-1:0]  match_index;

    match_scoreboard sb;
    int  send_max;
    int  recv_max;
    int  items_sent;
    bit  hold_off_req;
    int  cycle_count;

    substring_first_match dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .text_valid   (text_valid),
        .text_stall   (text_stall),
        .text_byte    (text_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .found        (found),
        .match_index  (match_index)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // result side: random stall per beat, one long hold-off on request
    initial
    begin
        int  n;
        bit  got;
        logic f;
        logic [15:0] mi;
        result_stall <= 1'b0;
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 0;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                result_stall <= 1'b0;
            end
            else
            begin
                n = $urandom_range(0, recv_max);
                if (n > 0)
                begin
                    result_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                    result_stall <= 1'b0;
                end
            end
            do
            begin
                @(negedge clk);
                got = result_valid && !result_stall;
                f   = found;
                mi  = match_index;
                @(posedge clk);
            end while (!got);
            sb.check_result(f, mi);
        end
    end

    task automatic send_byte(sfm_pkg::byte_t b, int gap);
        bit acc;
        if (gap > 0)
        begin
            text_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_valid <= 1'b1;
        text_byte  <= b;
        do
        begin
            @(negedge clk);
            acc = !text_stall;
            @(posedge clk);
        end while (!acc);
        sb.note_text(b);
        items_sent++;
    endtask

    task automatic send_string(sfm_pkg::byte_t q [$]);
        foreach (q[i])
            send_byte(q[i], $urandom_range(0, send_max));
        send_byte(8'd0, $urandom_range(0, send_max));
    endtask

    task automatic send_text(string s);
        sfm_pkg::byte_t q [$];
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
        send_string(q);
    endtask

    task automatic settle();
        text_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_reg(logic [sfm_pkg::CFG_IDX_BITS-1:0] idx, logic [63:0] v);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.write_reg(idx, v);
    endtask

    task automatic random_phase();
        sfm_pkg::byte_t    alph [4];
        sfm_pkg::byte_t    q [$];
        sfm_pkg::pattern_t pw;
        logic [63:0]       v;
        logic [4:0]        plen;
        logic [15:0]       lim;
        int                eff, r, nstr, slen, at, k;
        foreach (alph[i])
            alph[i] = $urandom_range(1, 255);
        r = $urandom_range(0, 19);
        if (r < 2)
            plen = 0;
        else if (r == 2)
            plen = 16;
        else if (r == 3)
            plen = $urandom_range(17, 31);
        else
            plen = $urandom_range(1, 6);
        eff = (plen > 16) ? 16 : plen;
        pw = {$urandom, $urandom, $urandom, $urandom};
        if ($urandom_range(0, 9) == 0)
        begin
            pw = '1;
            foreach (alph[i])
                alph[i] = 8'hFF;
        end
        for (k = 0; k < eff; k++)
            pw[k] = alph[$urandom_range(0, 3)];
        if (eff > 0 && $urandom_range(0, 14) == 0)
            pw[$urandom_range(0, eff - 1)] = 8'd0;
        r = $urandom_range(0, 9);
        if (r == 0)
            lim = 0;
        else if (r == 1)
            lim = $urandom_range(1, 30);
        else if (r == 2)
            lim = $urandom_range(0, 65535);
        else
            lim = 16'hFFFF;

        settle();
        set_reg(sfm_pkg::CFG_PAT_LOW, pw[7:0]);
        set_reg(sfm_pkg::CFG_PAT_HIGH, pw[15:8]);
        v = {$urandom, $urandom};
        v[4:0] = plen;
        set_reg(sfm_pkg::CFG_PAT_LEN, v);
        v = {$urandom, $urandom};
        v[15:0] = lim;
        set_reg(sfm_pkg::CFG_LIMIT, v);

        r = $urandom_range(0, 2);
        send_max = (r == 0) ? 0 : (r == 1) ? 4 : 18;
        r = $urandom_range(0, 2);
        recv_max = (r == 0) ? 0 : (r == 1) ? 4 : 18;

        nstr = $urandom_range(4, 12);
        repeat (nstr)
        begin
            q.delete();
            r = $urandom_range(0, 9);
            if (r == 1)
            begin
                slen = $urandom_range(1, 30);
                repeat (slen)
                    q.push_back($urandom_range(1, 255));
            end
            else if (r != 0)
            begin
                slen = $urandom_range(0, 24);
                repeat (slen)
                    q.push_back(alph[$urandom_range(0, 3)]);
                if (eff > 0 && $urandom_range(0, 9) < 6)
                begin
                    at = $urandom_range(0, q.size());
                    for (k = 0; k < eff; k++)
                        q.insert(at + k, (pw[k] == 8'd0) ? alph[0] : pw[k]);
                end
            end
            send_string(q);
        end
    endtask

    initial
    begin
        int target;
        rst_n      <= 1'b0;
        cfg_write  <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        text_valid <= 1'b0;
        text_byte  <= '0;
        send_max     = 6;
        recv_max     = 6;
        items_sent   = 0;
        hold_off_req = 0;
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset config: empty pattern, full limit; then an empty string
        send_text("X");
        send_text("");
        settle();
        set_reg(sfm_pkg::CFG_PAT_LOW, 64'h6261);
        set_reg(sfm_pkg::CFG_PAT_LEN, 64'd2);
        send_text("xab");
        send_text("zz");
        send_text("abab");
        settle();
        set_reg(sfm_pkg::CFG_LIMIT, 64'd2);
        send_text("xab");
        send_text("ab");
        settle();
        set_reg(sfm_pkg::CFG_PAT_LEN, 64'd0);
        set_reg(sfm_pkg::CFG_LIMIT, 64'd0);
        send_text("q");

        // fill the block while results are held off
        settle();
        set_reg(sfm_pkg::CFG_PAT_LOW, 64'h41);
        set_reg(sfm_pkg::CFG_PAT_LEN, 64'd1);
        set_reg(sfm_pkg::CFG_LIMIT, 64'hFFFF);
        send_max = 0;
        recv_max = 0;
        hold_off_req = 1;
        repeat (40)
            send_text("A");

        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
            random_phase();

        settle();
        repeat (16) @(posedge clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
